// File: rtl/core/wctm_pkg.sv
// Shared types and constants of the wall column texel mapper.
package wctm_pkg;

   localparam int DEF_WINDOW_HEIGHT = 512;
   localparam int DEF_WINDOW_WIDTH  = 1024;
   localparam int DEF_TILE_UNITS    = 64;

   localparam int FRAC_W    = 8;     // fraction bits of screen and world positions
   localparam int FRAC_HALF = 128;
   localparam int HIT_INT_W = 16;    // integer bits of a hit coordinate
   localparam int TEXEL_QW  = 13;    // quotient bits of the texel dividers
   localparam logic [12:0] TEXEL_MAX = 13'd4095;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 1'b1;
   localparam logic [15:0] LINE_BYTES_RST = 16'd4096;
   localparam logic [2:0]  BPP_RST        = 3'd4;

   typedef struct packed {
      logic [10:0]        column;
      logic [9:0]         row;
      logic signed [23:0] span_top;
      logic signed [23:0] span_bottom;
      logic [23:0]        hit_x;
      logic [23:0]        hit_y;
      logic               vertical_hit;
      logic [12:0]        texture_width;
      logic [12:0]        texture_height;
   } req_type;

   typedef struct packed {
      logic [10:0] screen_column;
      logic [9:0]  screen_row;
      logic [11:0] texel_x;
      logic [11:0] texel_y;
      logic [26:0] buffer_offset;
   } rsp_type;

endpackage

// File: rtl/core/wctm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
module wctm_div_pipe #(
   parameter int DW = 29,
   parameter int VW = 16,
   parameter int QW = 13,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_dividend,
   input  logic [VW-1:0] in_divisor,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic [VW-1:0] out_rem,
   output logic [SW-1:0] out_side
);

   localparam int CW = (DW > VW + QW) ? DW : VW + QW;

   logic          vld_ff  [QW];
   logic [CW-1:0] rem_ff  [QW];
   logic [QW-1:0] quot_ff [QW];
   logic [VW-1:0] dvs_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int SH = QW - 1 - s;

      logic          vld_src;
      logic [CW-1:0] rem_src;
      logic [QW-1:0] quot_src;
      logic [VW-1:0] dvs_src;
      logic [SW-1:0] side_src;
      logic [CW-1:0] trial;
      logic          take;
      logic [CW-1:0] rem_in;
      logic [QW-1:0] quot_in;

      if (s == 0) begin : g_head
         assign vld_src  = in_valid;
         assign rem_src  = CW'(in_dividend);
         assign quot_src = '0;
         assign dvs_src  = in_divisor;
         assign side_src = in_side;
      end else begin : g_link
         assign vld_src  = vld_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign quot_src = quot_ff[s-1];
         assign dvs_src  = dvs_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // compare against the divisor aligned to this quotient bit
      assign trial   = CW'(dvs_src) << SH;
      assign take    = (rem_src >= trial);
      assign rem_in  = take ? (rem_src - trial) : rem_src;
      assign quot_in = (quot_src << 1) | QW'(take);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         quot_ff[s] <= quot_in;
         dvs_ff[s]  <= dvs_src;
         side_ff[s] <= side_src;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_rem   = rem_ff[QW-1][VW-1:0];
   assign out_side  = side_ff[QW-1];

endmodule

// File: rtl/core/wall_column_texel_mapper.sv
// Top level of the wall column texel mapper: span test, texel mapping and byte offset.
//
// Takes one pixel request per clock while busy is low (busy is high only during reset) and
// returns at most one result word per request, in request order, as a one-cycle strobe on
// rsp_valid. Requests outside the wall span, with no positive wall height or off screen give
// no word. Each request passes in order through the span test stage, two tile modulo stages,
// a product stage, a divider setup stage, the 13-stage texel row divider and the output
// register. The tile modulo and the texel column divide by the tile size are reciprocal
// multiplies. The receiver cannot stall the block; it must take every word in the cycle it
// appears. CSR writes take effect on the next clock and are meant for times when no request
// is in flight.
module wall_column_texel_mapper
   import wctm_pkg::*;
#(
   parameter int WINDOW_HEIGHT = DEF_WINDOW_HEIGHT,
   parameter int WINDOW_WIDTH  = DEF_WINDOW_WIDTH,
   parameter int TILE_UNITS    = DEF_TILE_UNITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TILE_VW  = $clog2(TILE_UNITS + 1);
   localparam int MTW_W    = TILE_VW + 13;
   localparam int TILE_L   = $clog2(TILE_UNITS);
   localparam int MOD_K    = HIT_INT_W + TILE_L;
   localparam longint MOD_M = ((longint'(1) << MOD_K) + longint'(TILE_UNITS) - 1)
                            / longint'(TILE_UNITS);
   localparam int COL_K    = 25 + TILE_L;
   localparam longint COL_M = ((longint'(1) << COL_K) + longint'(TILE_UNITS) - 1)
                            / longint'(TILE_UNITS);

   typedef struct packed {
      logic [10:0] column;
      logic [9:0]  row;
      logic [12:0] tw;
      logic [12:0] th;
      logic [7:0]  frac;
      logic [15:0] height;
      logic [23:0] num;
   } mside_type;

   typedef struct packed {
      logic [10:0] column;
      logic [9:0]  row;
      logic [12:0] tw;
      logic [12:0] xq;
      logic [12:0] th;
      logic [26:0] offset;
      logic        over;
   } yside_type;

   function automatic logic [11:0] texel_clamp(input logic [12:0] q, input logic over,
                                               input logic [12:0] size);
      logic [12:0] lim;
      logic [12:0] pick;
      lim = ((size - 13'd1) < TEXEL_MAX) ? (size - 13'd1) : TEXEL_MAX;
      if (size == 13'd0) begin
         pick = 13'd0;
      end else begin
         pick = (over || (q > lim)) ? lim : q;
      end
      return pick[11:0];
   endfunction

   // ---------------- CSR ----------------
   logic [15:0] line_bytes_ff;
   logic [2:0]  bpp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_bytes_ff <= LINE_BYTES_RST;
         bpp_ff        <= BPP_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINE_BYTES: begin
               line_bytes_ff <= csr_wdata;
            end
            CSR_BYTES_PER_PIXEL: begin
               bpp_ff <= csr_wdata[2:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- stage 1: span test ----------------
   logic        req_accept;
   logic [24:0] span_diff;
   logic        height_pos;
   logic        top_ok;
   logic        bottom_ok;
   logic        column_ok;
   logic        keep;

   assign busy       = reset;
   assign req_accept = start && !busy;

   assign span_diff  = {req_data.span_bottom[23], req_data.span_bottom}
                     - {req_data.span_top[23], req_data.span_top};
   assign height_pos = !span_diff[24] && (span_diff[23:8] != 16'd0);
   // negative top truncates to zero or below, so any row passes
   assign top_ok     = req_data.span_top[23]
                    || ({5'd0, req_data.row} >= req_data.span_top[22:8]);
   assign bottom_ok  = !req_data.span_bottom[23]
                    && ({5'd0, req_data.row} < req_data.span_bottom[22:8])
                    && ({1'b0, req_data.row} < 11'(WINDOW_HEIGHT));
   assign column_ok  = ({1'b0, req_data.column} < 12'(WINDOW_WIDTH));
   assign keep       = height_pos && top_ok && bottom_ok && column_ok;

   logic        s1_vld_ff;
   logic [10:0] s1_column_ff;
   logic [9:0]  s1_row_ff;
   logic [15:0] s1_height_ff;
   logic [12:0] s1_tw_ff;
   logic [12:0] s1_th_ff;
   logic [23:0] s1_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_accept && keep;
      end
   end

   always_ff @(posedge clock) begin
      s1_column_ff <= req_data.column;
      s1_row_ff    <= req_data.row;
      s1_height_ff <= span_diff[23:8];
      s1_tw_ff     <= req_data.texture_width;
      s1_th_ff     <= req_data.texture_height;
      s1_hit_ff    <= req_data.vertical_hit ? req_data.hit_y : req_data.hit_x;
   end

   // ---------------- tile modulo ----------------
   logic [24:0]        s1_num;
   mside_type          mside_in;
   logic [32:0]        mod_prod;
   logic               m1_vld_ff;
   logic [15:0]        m1_quot_ff;
   logic [15:0]        m1_hit_ff;
   mside_type          m1_side_ff;
   logic               m2_vld_ff;
   logic [TILE_VW-1:0] m2_rem_ff;
   mside_type          m2_side_ff;
   mside_type          mside_out;
   logic               m_vld;
   logic [TILE_VW-1:0] m_rem;

   assign s1_num = 25'({s1_row_ff, {FRAC_W{1'b0}}})
                 + 25'({s1_height_ff, {(FRAC_W - 1){1'b0}}})
                 - 25'(WINDOW_HEIGHT * FRAC_HALF);

   always_comb begin
      mside_in.column = s1_column_ff;
      mside_in.row    = s1_row_ff;
      mside_in.tw     = s1_tw_ff;
      mside_in.th     = s1_th_ff;
      mside_in.frac   = s1_hit_ff[FRAC_W-1:0];
      mside_in.height = s1_height_ff;
      // a negative numerator ends as texel row zero
      mside_in.num    = s1_num[24] ? 24'd0 : s1_num[23:0];
   end

   // exact quotient of the integer hit by the tile size via a rounded-up reciprocal
   assign mod_prod = {17'd0, s1_hit_ff[23:FRAC_W]} * {16'd0, 17'(MOD_M)};

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= s1_vld_ff;
         m2_vld_ff <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_quot_ff <= 16'(mod_prod >> MOD_K);
      m1_hit_ff  <= s1_hit_ff[23:FRAC_W];
      m1_side_ff <= mside_in;
      m2_rem_ff  <= TILE_VW'(m1_hit_ff - (m1_quot_ff * 16'(TILE_UNITS)));
      m2_side_ff <= m1_side_ff;
   end

   assign m_vld     = m2_vld_ff;
   assign m_rem     = m2_rem_ff;
   assign mside_out = m2_side_ff;

   // ---------------- stage 2: products ----------------
   logic [36:0]      nth_prod;
   logic [MTW_W-1:0] mtw_prod;
   logic [20:0]      ftw_prod;
   logic [25:0]      row_lb_prod;
   logic [13:0]      col_bpp_prod;

   assign nth_prod     = {13'd0, mside_out.num} * {24'd0, mside_out.th};
   assign mtw_prod     = MTW_W'(m_rem) * MTW_W'(mside_out.tw);
   assign ftw_prod     = {13'd0, mside_out.frac} * {8'd0, mside_out.tw};
   assign row_lb_prod  = {16'd0, mside_out.row} * {10'd0, line_bytes_ff};
   assign col_bpp_prod = {3'd0, mside_out.column} * {11'd0, bpp_ff};

   logic        s2_vld_ff;
   logic [10:0] s2_column_ff;
   logic [9:0]  s2_row_ff;
   logic [12:0] s2_tw_ff;
   logic [12:0] s2_th_ff;
   logic [15:0] s2_height_ff;
   logic [28:0] s2_p8_ff;
   logic [24:0] s2_mtw_ff;
   logic [12:0] s2_ftw_ff;
   logic [26:0] s2_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= m_vld;
      end
   end

   always_ff @(posedge clock) begin
      s2_column_ff <= mside_out.column;
      s2_row_ff    <= mside_out.row;
      s2_tw_ff     <= mside_out.tw;
      s2_th_ff     <= mside_out.th;
      s2_height_ff <= mside_out.height;
      s2_p8_ff     <= nth_prod[36:FRAC_W];
      s2_mtw_ff    <= 25'(mtw_prod);
      s2_ftw_ff    <= ftw_prod[20:FRAC_W];
      s2_offset_ff <= 27'(row_lb_prod) + 27'(col_bpp_prod);
   end

   // ---------------- stage 3: divider setup ----------------
   logic        s3_vld_ff;
   logic [10:0] s3_column_ff;
   logic [9:0]  s3_row_ff;
   logic [12:0] s3_tw_ff;
   logic [12:0] s3_th_ff;
   logic [26:0] s3_offset_ff;
   logic        s3_over_ff;
   logic [28:0] s3_ydiv_ff;
   logic [15:0] s3_height_ff;
   logic [24:0] s3_xdiv_ff;
   logic        y_over_in;

   // quotient too big for the divider: saturate later
   assign y_over_in = (s2_p8_ff >= {s2_height_ff, {TEXEL_QW{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_column_ff <= s2_column_ff;
      s3_row_ff    <= s2_row_ff;
      s3_tw_ff     <= s2_tw_ff;
      s3_th_ff     <= s2_th_ff;
      s3_offset_ff <= s2_offset_ff;
      s3_over_ff   <= y_over_in;
      s3_ydiv_ff   <= y_over_in ? 29'd0 : s2_p8_ff;
      s3_height_ff <= s2_height_ff;
      s3_xdiv_ff   <= s2_mtw_ff + 25'(s2_ftw_ff);
   end

   // ---------------- texel divider ----------------
   yside_type            yside_in;
   yside_type            yside_out;
   logic                 y_vld;
   logic [TEXEL_QW-1:0]  y_quot;
   logic [50:0]          col_prod;
   logic [TEXEL_QW-1:0]  x_quot;

   // texel column by reciprocal multiply; rides along the row divider
   assign col_prod = {26'd0, s3_xdiv_ff} * {25'd0, 26'(COL_M)};
   assign x_quot   = TEXEL_QW'(col_prod >> COL_K);

   always_comb begin
      yside_in.column = s3_column_ff;
      yside_in.row    = s3_row_ff;
      yside_in.tw     = s3_tw_ff;
      yside_in.xq     = x_quot;
      yside_in.th     = s3_th_ff;
      yside_in.offset = s3_offset_ff;
      yside_in.over   = s3_over_ff;
   end

   wctm_div_pipe #(
      .DW (29),
      .VW (16),
      .QW (TEXEL_QW),
      .SW ($bits(yside_type))
   ) u_row_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s3_vld_ff),
      .in_dividend (s3_ydiv_ff),
      .in_divisor  (s3_height_ff),
      .in_side     (yside_in),
      .out_valid   (y_vld),
      .out_quot    (y_quot),
      .out_rem     (),
      .out_side    (yside_out)
   );

   // ---------------- output register ----------------
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= y_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.screen_column <= yside_out.column;
      rsp_data_ff.screen_row    <= yside_out.row;
      rsp_data_ff.texel_x       <= texel_clamp(yside_out.xq, 1'b0, yside_out.tw);
      rsp_data_ff.texel_y       <= texel_clamp(y_quot, yside_out.over, yside_out.th);
      rsp_data_ff.buffer_offset <= yside_out.offset;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/wctm_checker.sv
// Port-level assertions for the wall column texel mapper, bound to the top level.
module wctm_checker
   import wctm_pkg::*;
#(
   parameter int WINDOW_HEIGHT = DEF_WINDOW_HEIGHT,
   parameter int WINDOW_WIDTH  = DEF_WINDOW_WIDTH
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   localparam int LATENCY  = TEXEL_QW + 6;

   // reset flushes the pipeline
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   a_word_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result word without a request at fixed latency");

   a_word_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.screen_row == $past(req_data.row, LATENCY))
                 && (rsp_data.screen_column == $past(req_data.column, LATENCY)))
      else $error("result word position does not match its request");

   a_word_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.screen_row} < 11'(WINDOW_HEIGHT))
                 && ({1'b0, rsp_data.screen_column} < 12'(WINDOW_WIDTH)))
      else $error("result word off screen");

endmodule

bind wall_column_texel_mapper wctm_checker #(
   .WINDOW_HEIGHT (WINDOW_HEIGHT),
   .WINDOW_WIDTH  (WINDOW_WIDTH)
) u_wctm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
